// File: rtl/waveform_frame_builder_core_macros.svh
// Assertion macros used by the checker file of the frame builder.
// Depends on nothing; include with the bare file name.
`ifndef WAVEFORM_FRAME_BUILDER_CORE_MACROS_SVH
`define WAVEFORM_FRAME_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frame builder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frame builder check failed");

`endif

// File: rtl/wfb_pkg.sv
// Types and constants of the waveform frame builder.
// Used by every module of the block; depends on nothing.
package wfb_pkg;

	// Frame limits and fixed header bytes
	localparam logic [15:0] MAX_SAMPLES  = 16'd1024;
	localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND  = 8'h55;
	localparam logic [7:0]  BYTE_ZERO    = 8'h00;
	localparam int          HEADER_BYTES = 5;

	// Input actions
	localparam logic ACT_BEGIN  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Error codes
	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_COUNT   = 2'd1;
	localparam logic [1:0] ERR_OUTSIDE = 2'd2;

	// Job queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Byte index inside one job: header plus checksum is the longest
	localparam int BIDX_W = $clog2(HEADER_BYTES + 1);

	typedef struct packed {
		logic        action;
		logic [15:0] sample_count;
		logic [15:0] sample_value;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       last_of_frame;
		logic [1:0] error_code;
	} result_t;

	typedef enum logic [1:0] {
		JOB_HEADER,
		JOB_SAMPLE,
		JOB_ERROR
	} job_kind_t;

	// One classified transaction: word is the count or the sample,
	// close appends the checksum byte csum marked last.
	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] word;
		logic        close;
		logic [7:0]  csum;
		logic [1:0]  err;
	} job_t;

endpackage

// File: rtl/waveform_frame_builder_core.sv
// Waveform frame builder, top level: configuration register, front end,
// job queue and back end. Depends on wfb_pkg, wfb_front, wfb_queue, wfb_back.
//
// Usage:
//   item channel (item_valid/item_stall/item): begin transactions carry a
//   sample count, sample transactions carry one 16-bit sample.
//   result channel (result_valid/result_stall/result): one frame byte per
//   transaction, in transmit order; last_of_frame marks the checksum byte
//   and every error result.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the header command
//   byte; cfg_ready is always high. Write it only while the block is idle.
//   Accepted transactions enter the job queue; their bytes then leave through
//   the single byte output register, which sends one byte per cycle while the
//   result is not stalled: two bytes per sample (three when it closes the
//   frame), five or six per header and one per error. It sets the throughput.
//   A four-entry job queue lets the front end accept while the back end
//   drains; item_stall rises only when the queue is full.
//   Reset clears the frame state, the queue and the command byte.
//   A stalled result holds its byte until taken.
module waveform_frame_builder_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wfb_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output wfb_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	logic          cmd_q;
	logic [7:0]    command_code_q;
	logic          push;
	wfb_pkg::job_t push_job;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	wfb_pkg::job_t head;

	// Command byte register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_code_q <= 8'd0;
			cmd_q          <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			command_code_q <= cfg_data;
			cmd_q          <= 1'b1;
		end
	end

	wfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	wfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// Send zero as command byte until the first write, as reset gives
	wfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.command_code (cmd_q ? command_code_q : 8'd0),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: rtl/wfb_front.sv
// Front end: accepts input transactions, tracks the open frame and
// turns each transaction into one job. Depends on wfb_pkg.
module wfb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  wfb_pkg::item_t item,
	output logic           push,
	output wfb_pkg::job_t  push_job,
	input  logic           q_full
);

	logic [15:0] samples_left_q;
	logic [7:0]  running_xor_q;
	logic        in_frame_q;

	logic        accept;
	logic [7:0]  xor_next;
	logic        frame_done;
	logic        count_bad;

	// Stall while the queue has no room
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign push       = accept;

	assign xor_next   = running_xor_q ^ item.sample_value[7:0] ^ item.sample_value[15:8];
	assign frame_done = (samples_left_q == 16'd1);
	assign count_bad  = (item.sample_count > wfb_pkg::MAX_SAMPLES);

	// Classify the transaction into a job
	always_comb begin
		push_job.kind  = wfb_pkg::JOB_ERROR;
		push_job.word  = 16'd0;
		push_job.close = 1'b0;
		push_job.csum  = wfb_pkg::BYTE_ZERO;
		push_job.err   = wfb_pkg::ERR_OK;
		if (item.action == wfb_pkg::ACT_BEGIN) begin
			if (count_bad) begin
				push_job.err = wfb_pkg::ERR_COUNT;
			end else begin
				push_job.kind  = wfb_pkg::JOB_HEADER;
				push_job.word  = item.sample_count;
				push_job.close = (item.sample_count == 16'd0);
			end
		end else if (!in_frame_q) begin
			push_job.err = wfb_pkg::ERR_OUTSIDE;
		end else begin
			push_job.kind  = wfb_pkg::JOB_SAMPLE;
			push_job.word  = item.sample_value;
			push_job.close = frame_done;
			push_job.csum  = xor_next;
		end
	end

	// Advance the frame state on every accepted valid begin or in-frame sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_left_q <= 16'd0;
			running_xor_q  <= 8'd0;
			in_frame_q     <= 1'b0;
		end else if (accept) begin
			if (item.action == wfb_pkg::ACT_BEGIN) begin
				if (!count_bad) begin
					samples_left_q <= item.sample_count;
					running_xor_q  <= 8'd0;
					in_frame_q     <= (item.sample_count != 16'd0);
				end
			end else if (in_frame_q) begin
				samples_left_q <= samples_left_q - 16'd1;
				running_xor_q  <= frame_done ? 8'd0 : xor_next;
				in_frame_q     <= !frame_done;
			end
		end
	end

endmodule

// File: rtl/wfb_queue.sv
// Short job queue in flip-flops that decouples front and back.
// Depends on wfb_pkg for the job type and depth.
module wfb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wfb_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output wfb_pkg::job_t head,
	output logic          empty
);

	wfb_pkg::job_t                   slot_q [wfb_pkg::QDEPTH];
	logic [wfb_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [wfb_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [wfb_pkg::QCNT_W-1:0]      count_q;

	localparam logic [wfb_pkg::QPTR_W-1:0] PTR_LAST = wfb_pkg::QPTR_W'(wfb_pkg::QDEPTH - 1);
	localparam logic [wfb_pkg::QPTR_W-1:0] PTR_ONE  = wfb_pkg::QPTR_W'(1);
	localparam logic [wfb_pkg::QCNT_W-1:0] CNT_FULL = wfb_pkg::QCNT_W'(wfb_pkg::QDEPTH);
	localparam logic [wfb_pkg::QCNT_W-1:0] CNT_ONE  = wfb_pkg::QCNT_W'(1);

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Write the new job into its slot
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

// File: rtl/wfb_back.sv
// Back end: walks the job at the queue head one byte per cycle, while the
// output is not stalled, into a registered output stage. Depends on wfb_pkg.
module wfb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  wfb_pkg::job_t    head,
	input  logic             q_empty,
	output logic             pop,
	input  logic [7:0]       command_code,
	output logic             result_valid,
	input  logic             result_stall,
	output wfb_pkg::result_t result
);

	logic [wfb_pkg::BIDX_W-1:0] idx_q;
	logic                       result_valid_q;
	wfb_pkg::result_t           result_q;

	logic [wfb_pkg::BIDX_W-1:0] last_idx;
	logic                       load;
	logic                       at_last;
	wfb_pkg::result_t           next_res;

	localparam logic [wfb_pkg::BIDX_W-1:0] IDX_HDR_END = wfb_pkg::BIDX_W'(wfb_pkg::HEADER_BYTES - 1);
	localparam logic [wfb_pkg::BIDX_W-1:0] IDX_0 = wfb_pkg::BIDX_W'(0);
	localparam logic [wfb_pkg::BIDX_W-1:0] IDX_1 = wfb_pkg::BIDX_W'(1);
	localparam logic [wfb_pkg::BIDX_W-1:0] IDX_2 = wfb_pkg::BIDX_W'(2);
	localparam logic [wfb_pkg::BIDX_W-1:0] IDX_3 = wfb_pkg::BIDX_W'(3);
	localparam logic [wfb_pkg::BIDX_W-1:0] IDX_4 = wfb_pkg::BIDX_W'(4);

	// Index of the final byte of the head job
	always_comb begin
		unique case (head.kind)
			wfb_pkg::JOB_HEADER: last_idx = IDX_HDR_END + wfb_pkg::BIDX_W'(head.close);
			wfb_pkg::JOB_SAMPLE: last_idx = IDX_1 + wfb_pkg::BIDX_W'(head.close);
			default:             last_idx = IDX_0;
		endcase
	end

	assign load    = !q_empty && (!result_valid_q || !result_stall);
	assign at_last = (idx_q == last_idx);
	assign pop     = load && at_last;

	// Pick the byte for the current index
	always_comb begin
		next_res.byte_out      = wfb_pkg::BYTE_ZERO;
		next_res.last_of_frame = at_last && head.close;
		next_res.error_code    = wfb_pkg::ERR_OK;
		unique case (head.kind)
			wfb_pkg::JOB_HEADER: begin
				unique case (idx_q)
					IDX_0:   next_res.byte_out = wfb_pkg::SYNC_FIRST;
					IDX_1:   next_res.byte_out = wfb_pkg::SYNC_SECOND;
					IDX_2:   next_res.byte_out = command_code;
					IDX_3:   next_res.byte_out = head.word[7:0];
					IDX_4:   next_res.byte_out = head.word[15:8];
					default: next_res.byte_out = head.csum;
				endcase
			end
			wfb_pkg::JOB_SAMPLE: begin
				unique case (idx_q)
					IDX_0:   next_res.byte_out = head.word[7:0];
					IDX_1:   next_res.byte_out = head.word[15:8];
					default: next_res.byte_out = head.csum;
				endcase
			end
			default: begin
				next_res.last_of_frame = 1'b1;
				next_res.error_code    = head.err;
			end
		endcase
	end

	// Hold the output while stalled, advance the byte index on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_last ? '0 : idx_q + IDX_1;
			end
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= next_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/wfb_checker.sv
// Port-level checks of the frame builder, bound to the top level.
// Depends on wfb_pkg and waveform_frame_builder_core_macros.svh.
`include "waveform_frame_builder_core_macros.svh"

module wfb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input wfb_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input wfb_pkg::result_t result,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [7:0]       cfg_data
);

	logic err_result;
	logic err_closed;
	logic err_known;
	logic item_waits;
	logic result_waits;

	assign err_result   = result_valid && (result.error_code != wfb_pkg::ERR_OK);
	assign err_closed   = result.last_of_frame && (result.byte_out == wfb_pkg::BYTE_ZERO);
	assign err_known    = (result.error_code == wfb_pkg::ERR_OK)
		|| (result.error_code == wfb_pkg::ERR_COUNT)
		|| (result.error_code == wfb_pkg::ERR_OUTSIDE);
	assign item_waits   = item_valid && item_stall;
	assign result_waits = result_valid && result_stall;

	// An error result is a lone zero byte that closes its transaction
	`WFB_ASSERT_IMPLY(a_err_is_last, clk, arst_n, err_result, err_closed)
	// Only defined error codes leave the block
	`WFB_ASSERT_IMPLY(a_err_code_known, clk, arst_n, result_valid, err_known)
	// A stalled result stays put
	`WFB_ASSERT_NEXT(a_result_hold, clk, arst_n, result_waits, result_valid && $stable(result))
	// A stalled input transaction stays put
	`WFB_ASSERT_NEXT(a_item_hold, clk, arst_n, item_waits, item_valid && $stable(item))
	// The configuration port never back-pressures and carries known data
	`WFB_ASSERT_IMPLY(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready && !$isunknown(cfg_data))

endmodule

bind waveform_frame_builder_core wfb_checker u_wfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_data     (cfg_data)
);
